### rtl/b85le_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package b85le_pkg;

    // Digits per group and the largest group weight (85^4)
    localparam int unsigned GROUP_DIGITS = 5;
    localparam logic [2:0]  LAST_POS     = 3'd4;
    localparam int unsigned WEIGHT_W     = 26;

    // Result of the character lookup
    typedef struct packed {
        logic       valid;
        logic [6:0] digit;
    } digit_t;

    // One group of results handed from the accumulator to the serializer
    typedef struct packed {
        logic [31:0] word;   // bytes to send, lowest byte first
        logic [2:0]  count;  // number of results, 1..4
        logic        last;   // final result of the burst ends the text
        logic        bytes;  // results carry decoded bytes
        logic        err;    // single error result
    } burst_t;

    // Map a Z85 character to its digit
    function automatic digit_t digit_of(input logic [7:0] code);
        digit_t r;
        r.valid = 1'b1;
        r.digit = 7'd0;
        if (code >= 8'h30 && code <= 8'h39) begin
            r.digit = 7'(code - 8'h30);
        end else if (code >= 8'h61 && code <= 8'h7A) begin
            r.digit = 7'(code - 8'h61 + 8'd10);
        end else if (code >= 8'h41 && code <= 8'h5A) begin
            r.digit = 7'(code - 8'h41 + 8'd36);
        end else begin
            case (code)
                8'h2E: r.digit = 7'd62;  // .
                8'h2D: r.digit = 7'd63;  // -
                8'h3A: r.digit = 7'd64;  // :
                8'h2B: r.digit = 7'd65;  // +
                8'h3D: r.digit = 7'd66;  // =
                8'h5E: r.digit = 7'd67;  // ^
                8'h21: r.digit = 7'd68;  // !
                8'h2F: r.digit = 7'd69;  // /
                8'h2A: r.digit = 7'd70;  // *
                8'h3F: r.digit = 7'd71;  // ?
                8'h26: r.digit = 7'd72;  // &
                8'h3C: r.digit = 7'd73;  // <
                8'h3E: r.digit = 7'd74;  // >
                8'h28: r.digit = 7'd75;  // (
                8'h29: r.digit = 7'd76;  // )
                8'h5B: r.digit = 7'd77;  // [
                8'h5D: r.digit = 7'd78;  // ]
                8'h7B: r.digit = 7'd79;  // {
                8'h7D: r.digit = 7'd80;  // }
                8'h40: r.digit = 7'd81;  // @
                8'h25: r.digit = 7'd82;  // %
                8'h24: r.digit = 7'd83;  // $
                8'h23: r.digit = 7'd84;  // #
                default: r.valid = 1'b0;
            endcase
        end
        return r;
    endfunction

    // Weight of digit position j: 85^j
    function automatic logic [WEIGHT_W-1:0] weight_of(input logic [2:0] pos);
        logic [WEIGHT_W-1:0] w;
        case (pos)
            3'd0:    w = WEIGHT_W'(1);
            3'd1:    w = WEIGHT_W'(85);
            3'd2:    w = WEIGHT_W'(85 * 85);
            3'd3:    w = WEIGHT_W'(85 * 85 * 85);
            3'd4:    w = WEIGHT_W'(85 * 85 * 85 * 85);
            default: w = WEIGHT_W'(0);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

### rtl/b85le_accum.sv
`timescale 1ns / 1ps
`default_nettype none
module b85le_accum (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_code,
    input  wire logic              in_eot,
    output logic                   burst_valid,
    output b85le_pkg::burst_t      burst,
    input  wire logic              burst_ready
);

    logic        hold_reg, hold_next;
    logic [7:0]  code_reg;
    logic        eot_reg;
    logic [31:0] group_reg, group_next;
    logic [2:0]  pos_reg, pos_next;
    logic        drop_reg, drop_next;

    b85le_pkg::digit_t              map;
    logic [b85le_pkg::WEIGHT_W-1:0] weight;
    logic [31:0]                    product;
    logic [31:0]                    sum;
    logic [2:0]                     new_pos;
    logic                           group_full;
    logic                           produce;
    logic                           advance;

    // Look up the digit and weight it by its position
    always_comb
    begin
        map        = b85le_pkg::digit_of(code_reg);
        weight     = b85le_pkg::weight_of(pos_reg);
        product    = 32'(map.digit) * 32'(weight);
        sum        = group_reg + product;
        new_pos    = pos_reg + 3'd1;
        group_full = (pos_reg == b85le_pkg::LAST_POS);
        produce    = hold_reg && !drop_reg && (!map.valid || group_full || eot_reg);
        advance    = hold_reg && (!produce || burst_ready);
        in_ready   = !hold_reg || advance;
    end

    // Build the burst for a group that closes
    always_comb
    begin
        burst_valid = advance && produce;
        burst.word  = 32'd0;
        burst.count = 3'd1;
        burst.last  = 1'b1;
        burst.bytes = 1'b0;
        burst.err   = 1'b0;
        if (!map.valid) begin
            burst.err = 1'b1;
        end else if (group_full) begin
            burst.word  = sum;
            burst.count = 3'd4;
            burst.last  = eot_reg;
            burst.bytes = 1'b1;
        end else if (pos_reg != 3'd0) begin
            burst.word  = sum;
            burst.count = new_pos - 3'd1;
            burst.bytes = 1'b1;
        end
    end

    // Update group state when the held word moves on
    always_comb
    begin
        group_next = group_reg;
        pos_next   = pos_reg;
        drop_next  = drop_reg;
        if (advance) begin
            if (drop_reg) begin
                if (eot_reg) begin
                    drop_next = 1'b0;
                end
            end else if (!map.valid) begin
                group_next = 32'd0;
                pos_next   = 3'd0;
                drop_next  = !eot_reg;
            end else if (produce) begin
                group_next = 32'd0;
                pos_next   = 3'd0;
            end else begin
                group_next = sum;
                pos_next   = new_pos;
            end
        end
        hold_next = hold_reg;
        if (in_ready) begin
            hold_next = in_valid;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_reg  <= 1'b0;
            group_reg <= 32'd0;
            pos_reg   <= 3'd0;
            drop_reg  <= 1'b0;
        end else begin
            hold_reg  <= hold_next;
            group_reg <= group_next;
            pos_reg   <= pos_next;
            drop_reg  <= drop_next;
        end
    end

    // Capture the incoming word
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            code_reg <= in_code;
            eot_reg  <= in_eot;
        end
    end

endmodule
`default_nettype wire

### rtl/b85le_serial.sv
`timescale 1ns / 1ps
`default_nettype none
module b85le_serial (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              burst_valid,
    input  wire b85le_pkg::burst_t burst,
    output logic                   burst_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   out_byte_valid,
    output logic                   out_last,
    output logic                   out_error
);

    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] word_reg, word_next;
    logic        last_reg, last_next;
    logic        bytes_reg, bytes_next;
    logic        err_reg, err_next;
    logic        take;

    // Drive the current result
    always_comb
    begin
        out_valid      = (cnt_reg != 3'd0);
        take           = out_valid && out_ready;
        burst_ready    = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && out_ready);
        out_byte       = word_reg[7:0];
        out_byte_valid = bytes_reg;
        out_error      = err_reg;
        out_last       = last_reg && (cnt_reg == 3'd1);
    end

    // Load a new burst or shift out the next byte
    always_comb
    begin
        cnt_next   = cnt_reg;
        word_next  = word_reg;
        last_next  = last_reg;
        bytes_next = bytes_reg;
        err_next   = err_reg;
        if (burst_valid) begin
            cnt_next   = burst.count;
            word_next  = burst.word;
            last_next  = burst.last;
            bytes_next = burst.bytes;
            err_next   = burst.err;
        end else if (take) begin
            cnt_next  = cnt_reg - 3'd1;
            word_next = {8'd0, word_reg[31:8]};
        end
    end

    // Result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 3'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        last_reg  <= last_next;
        bytes_reg <= bytes_next;
        err_reg   <= err_next;
    end

endmodule
`default_nettype wire

### rtl/base85_le_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Output path: m_tvalid rises once a group's closing word has passed the input register
// and been loaded into the serializer, which waits while an earlier burst still drains.
// Throughput: one character word per cycle while the serializer takes each closing group;
// it sends up to 4 results, one per cycle while m_tready is high, as the next group builds.
// A burst is taken by the serializer only once its previous burst is empty or its last result is taken.
// Reset (rst_n low, asynchronous) clears the group sum, digit count, drop flag and queue.
module base85_le_decoder_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_code
    input  wire logic       s_tlast,   // end_of_text
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] data_byte
    output logic [1:0]      m_tuser,   // [0] byte_valid, [1] error
    output logic            m_tlast    // last
);

    logic              burst_valid;
    logic              burst_ready;
    b85le_pkg::burst_t burst;
    logic              byte_valid;
    logic              err;

    b85le_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_code     (s_tdata),
        .in_eot      (s_tlast),
        .burst_valid (burst_valid),
        .burst       (burst),
        .burst_ready (burst_ready)
    );

    b85le_serial u_serial (
        .clk            (clk),
        .rst_n          (rst_n),
        .burst_valid    (burst_valid),
        .burst          (burst),
        .burst_ready    (burst_ready),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_byte       (m_tdata),
        .out_byte_valid (byte_valid),
        .out_last       (m_tlast),
        .out_error      (err)
    );

    assign m_tuser = {err, byte_valid};

    // A burst is only handed over when the serializer can take it
    a_burst_fits: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid |-> burst_ready)
        else $error("burst handed over while serializer busy");

    // An error result never carries a byte
    a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("error result marked as byte");

    // Marker and error results always end the text
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("marker result without last");

    // A burst of error results is exactly one result long
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (burst_valid && burst.err) |-> (burst.count == 3'd1 && burst.last))
        else $error("error burst malformed");

endmodule
`default_nettype wire

### test/base85_le_decoder_top_tb.sv
`timescale 1ns / 1ps

module base85_le_decoder_top_tb;

    localparam int    CYCLE_LIMIT = 400000;
    localparam int    SHOW_LIMIT  = 10;
    localparam string Z85_CHARS   =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

    // One decoded result as it leaves the block
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       err;
    } out_word_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    // Decoder state mirrored on the testbench side
    logic [31:0] grp_sum    = 32'd0;
    logic [2:0]  grp_digits = 3'd0;
    logic        skip_text  = 1'b0;

    out_word_t pending_words[$];
    int        mismatches = 0;
    int        chars_sent = 0;
    int        cycle_cnt  = 0;
    int        rdy_hold   = 0;
    bit        tx_steady  = 1'b0;
    bit        rx_steady  = 1'b0;

    base85_le_decoder_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    // Digit value of a character, -1 outside the alphabet
    function automatic int z85_digit(input logic [7:0] code);
        for (int i = 0; i < 85; i++) begin
            if (Z85_CHARS[i] == code) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] good_char();
        return Z85_CHARS[$urandom_range(0, 84)];
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (z85_digit(c) >= 0) begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // Accumulate one character and queue the words it releases
    function automatic void decode_char(input logic [7:0] code, input logic eot);
        int          d;
        int          nbytes;
        logic [31:0] weight;
        out_word_t   w;
        if (skip_text) begin
            if (eot) begin
                skip_text = 1'b0;
            end
            return;
        end
        d = z85_digit(code);
        if (d < 0) begin
            w = '{data: 8'd0, valid: 1'b0, last: 1'b1, err: 1'b1};
            pending_words.push_back(w);
            grp_sum    = 32'd0;
            grp_digits = 3'd0;
            skip_text  = !eot;
            return;
        end
        weight = 32'd1;
        repeat (grp_digits) weight = weight * 32'd85;
        grp_sum    = grp_sum + 32'(d) * weight;
        grp_digits = grp_digits + 3'd1;
        if (grp_digits == 3'd5) begin
            nbytes = 4;
        end else if (eot) begin
            nbytes = int'(grp_digits) - 1;
        end else begin
            return;
        end
        if (nbytes == 0) begin
            w = '{data: 8'd0, valid: 1'b0, last: 1'b1, err: 1'b0};
            pending_words.push_back(w);
        end else begin
            for (int i = 0; i < nbytes; i++) begin
                w.data  = grp_sum[8*i +: 8];
                w.valid = 1'b1;
                w.last  = eot && (i == nbytes - 1);
                w.err   = 1'b0;
                pending_words.push_back(w);
            end
        end
        grp_sum    = 32'd0;
        grp_digits = 3'd0;
    endfunction

    // Offer one character, wait for the handshake, then predict
    task automatic send_char(input logic [7:0] code, input logic eot);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        decode_char(code, eot);
        chars_sent++;
    endtask

    task automatic send_str(input string txt, input logic end_flag);
        for (int i = 0; i < txt.len(); i++) begin
            send_char(txt[i], end_flag && (i == txt.len() - 1));
        end
    endtask

    // Hold off the sender until every queued word has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Final groups of every size, including all-zero ones
    task automatic test_group_sizes();
        send_str("0", 1'b1);
        send_str("0#", 1'b1);
        send_str("#0a", 1'b1);
        send_str("Hi!#", 1'b1);
        send_str("00000", 1'b1);
        wait_drained();
    endtask

    // Invalid characters, dropping, and bytes already sent before an error
    task automatic test_bad_input();
        send_str("#####", 1'b0);
        send_char(8'hFF, 1'b0);
        send_str("xy", 1'b0);
        send_str("z", 1'b1);
        send_char(8'h00, 1'b1);
        wait_drained();
    endtask

    // Random texts, mostly well formed, some broken or pure noise
    task automatic test_random_text();
        int         goal;
        int         len;
        int         bad_at;
        bit         noise;
        logic [7:0] c;
        goal = chars_sent + 250;
        while (chars_sent < goal) begin
            if ($urandom_range(0, 5) == 0) begin
                tx_steady = !tx_steady;
            end
            if ($urandom_range(0, 5) == 0) begin
                rx_steady = !rx_steady;
            end
            len    = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 30);
            noise  = ($urandom_range(0, 11) == 0);
            bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : -1;
            for (int i = 0; i < len; i++) begin
                if (noise) begin
                    c = 8'($urandom_range(0, 255));
                end else if (i == bad_at) begin
                    c = bad_char();
                end else begin
                    c = good_char();
                end
                send_char(c, i == len - 1);
            end
            if ($urandom_range(0, 9) == 0) begin
                wait_drained();
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Receiver: runs of ready and stalls of random length
    always @(posedge clk) begin
        if (rdy_hold != 0) begin
            rdy_hold <= rdy_hold - 1;
        end else if (rx_steady || $urandom_range(0, 2) != 0) begin
            m_tready <= 1'b1;
            rdy_hold <= $urandom_range(0, 12);
        end else begin
            m_tready <= 1'b0;
            rdy_hold <= pick_gap();
        end
    end

    // Compare each accepted word with the oldest prediction
    always @(posedge clk) begin
        out_word_t got;
        out_word_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = '{data: m_tdata, valid: m_tuser[0], last: m_tlast, err: m_tuser[1]};
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT) begin
                    $display("unexpected word: data=%02h valid=%0b last=%0b err=%0b",
                             got.data, got.valid, got.last, got.err);
                end
            end else begin
                want = pending_words.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT) begin
                        $display("mismatch: exp data=%02h valid=%0b last=%0b err=%0b, got data=%02h valid=%0b last=%0b err=%0b",
                                 want.data, want.valid, want.last, want.err,
                                 got.data, got.valid, got.last, got.err);
                    end
                end
            end
        end
    end

    // Give up on a hung run
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("base85_le_decoder_top verification failed");
        $finish;
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_group_sizes();
        test_bad_input();
        test_random_text();
        wait_drained();
        repeat (16) @(posedge clk);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("base85_le_decoder_top verification clean");
        end else begin
            $display("base85_le_decoder_top verification failed");
        end
        $finish;
    end

endmodule
